@@ hdl/reminder_tone_pattern_sequencer_macros.svh @@
// assertion helpers used by the sequencer top level
`ifndef REMINDER_TONE_PATTERN_SEQUENCER_MACROS_SVH
`define REMINDER_TONE_PATTERN_SEQUENCER_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define RTPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtps check failed");

// next-cycle implication, checked on every clock edge outside reset
`define RTPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtps check failed");

`endif

@@ hdl/rtps_pkg.sv @@
`timescale 1ns / 1ps

package rtps_pkg;

    // default timestamp width
    localparam int TIME_WIDTH_DEF = 32;

    // timing constants, in milliseconds where named _MS, tone frequency in hertz
    localparam int          TOTAL_W       = 18;
    localparam logic [17:0] TOTAL_MS      = 18'd180000;
    localparam logic [15:0] PERIOD_MS     = 16'd30000;
    localparam logic [8:0]  LED_SLOW_MS   = 9'd500;
    localparam logic [8:0]  LED_QUICK_MS  = 9'd100;
    localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
    localparam logic [10:0] POWER_TONE_HZ = 11'd600;
    localparam logic [9:0]  POWER_TONE_MS = 10'd60;
    localparam logic [2:0]  NUM_PATTERNS  = 3'd5;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_SECONDS = 3'd0,
        REG_RHYTHM_SELECT = 3'd1,
        REG_SOUND_ENABLE  = 3'd2,
        REG_VOLUME_LEVEL  = 3'd3,
        REG_LED_ENABLE    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_TONE = 2'd1,
        CMD_MUTE = 2'd2
    } t_tone_cmd;

    typedef enum logic [2:0] {
        OC_RUNNING   = 3'd0,
        OC_ACK       = 3'd1,
        OC_PASSED    = 3'd2,
        OC_DISMISSED = 3'd3,
        OC_TIMEOUT   = 3'd4
    } t_outcome;

    typedef struct packed {
        logic [7:0] pulse_seconds;
        logic [2:0] rhythm_select;
        logic       sound_enable;
        logic [3:0] volume_level;
        logic       led_enable;
    } t_cfg;

    localparam logic [7:0] RST_PULSE_SECONDS = 8'd10;
    localparam logic [2:0] RST_RHYTHM_SELECT = 3'd0;
    localparam logic       RST_SOUND_ENABLE  = 1'b1;
    localparam logic [3:0] RST_VOLUME_LEVEL  = 4'd5;
    localparam logic       RST_LED_ENABLE    = 1'b1;

    // one input transaction, first field in the high bits
    typedef struct packed {
        logic        power_short;
        logic        press_b;
        logic        press_a;
        logic [31:0] now_ms;
    } t_item;

    // one result transaction, first field in the high bits
    typedef struct packed {
        logic        pulse_active;
        t_outcome    outcome;
        logic        led_level;
        logic [9:0]  tone_len_ms;
        logic [10:0] tone_hz;
        t_tone_cmd   tone_command;
    } t_result;

    localparam int ITEM_W     = $bits(t_item);
    localparam int RESULT_W   = $bits(t_result);
    localparam int S_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [10:0] hz;
        logic [9:0]  ms;
    } t_tone_step;

    // tone step rom, all five patterns back to back
    function automatic t_tone_step rom_step(input logic [5:0] addr);
        t_tone_step s;
        case (addr)
            6'd0:  s = '{11'd1500, 10'd200};
            6'd1:  s = '{11'd0,    10'd800};
            6'd2:  s = '{11'd1500, 10'd120};
            6'd3:  s = '{11'd0,    10'd80};
            6'd4:  s = '{11'd1500, 10'd120};
            6'd5:  s = '{11'd0,    10'd80};
            6'd6:  s = '{11'd1500, 10'd120};
            6'd7:  s = '{11'd0,    10'd480};
            6'd8:  s = '{11'd1200, 10'd800};
            6'd9:  s = '{11'd0,    10'd200};
            6'd10: s = '{11'd1500, 10'd120};
            6'd11: s = '{11'd0,    10'd80};
            6'd12: s = '{11'd1500, 10'd120};
            6'd13: s = '{11'd0,    10'd80};
            6'd14: s = '{11'd1500, 10'd120};
            6'd15: s = '{11'd0,    10'd240};
            6'd16: s = '{11'd1500, 10'd320};
            6'd17: s = '{11'd0,    10'd80};
            6'd18: s = '{11'd1500, 10'd320};
            6'd19: s = '{11'd0,    10'd80};
            6'd20: s = '{11'd1500, 10'd320};
            6'd21: s = '{11'd0,    10'd240};
            6'd22: s = '{11'd1500, 10'd120};
            6'd23: s = '{11'd0,    10'd80};
            6'd24: s = '{11'd1500, 10'd120};
            6'd25: s = '{11'd0,    10'd80};
            6'd26: s = '{11'd1500, 10'd120};
            6'd27: s = '{11'd0,    10'd480};
            6'd28: s = '{11'd800,  10'd180};
            6'd29: s = '{11'd0,    10'd40};
            6'd30: s = '{11'd1200, 10'd180};
            6'd31: s = '{11'd0,    10'd40};
            6'd32: s = '{11'd1800, 10'd220};
            6'd33: s = '{11'd0,    10'd400};
            default: s = '{11'd0,  10'd0};
        endcase
        return s;
    endfunction

    // first rom entry of each pattern
    function automatic logic [5:0] pat_base(input logic [2:0] r);
        logic [5:0] b;
        case (r)
            3'd1:    b = 6'd2;
            3'd2:    b = 6'd8;
            3'd3:    b = 6'd10;
            3'd4:    b = 6'd28;
            default: b = 6'd0;
        endcase
        return b;
    endfunction

    // number of steps in each pattern
    function automatic logic [4:0] pat_len(input logic [2:0] r);
        logic [4:0] n;
        case (r)
            3'd1:    n = 5'd6;
            3'd2:    n = 5'd2;
            3'd3:    n = 5'd18;
            3'd4:    n = 5'd6;
            default: n = 5'd2;
        endcase
        return n;
    endfunction

endpackage

@@ hdl/reminder_tone_pattern_sequencer.sv @@
// pipeline: a sample enters the input register, and its result is held in the
//   result register until its result transaction completes
// throughput: one sample per cycle unless the result stream stalls; the state update for one
//   sample is a single pass through the step logic between the input and result registers
// reset: synchronous active low; clears the sequencer state, empties both
//   pipeline registers and restores the configuration register defaults
`timescale 1ns / 1ps
`include "reminder_tone_pattern_sequencer_macros.svh"

module reminder_tone_pattern_sequencer #(
    parameter int TIME_WIDTH = rtps_pkg::TIME_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [rtps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sample stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rtps_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // now_ms, press_a, press_b, power_short
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rtps_pkg::M_TDATA_W-1:0]   m_axis_tdata   // tone_command, tone_hz, tone_len_ms,
                                                            // led_level, outcome, pulse_active
);
    import rtps_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    t_result w_res;
    logic    w_advance;
    logic    w_step;
    logic    w_s_accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_seconds <= RST_PULSE_SECONDS;
            r_cfg.rhythm_select <= RST_RHYTHM_SELECT;
            r_cfg.sound_enable  <= RST_SOUND_ENABLE;
            r_cfg.volume_level  <= RST_VOLUME_LEVEL;
            r_cfg.led_enable    <= RST_LED_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PULSE_SECONDS: r_cfg.pulse_seconds <= i_cfg_data;
                REG_RHYTHM_SELECT: r_cfg.rhythm_select <= i_cfg_data[2:0];
                REG_SOUND_ENABLE:  r_cfg.sound_enable  <= i_cfg_data[0];
                REG_VOLUME_LEVEL:  r_cfg.volume_level  <= i_cfg_data[3:0];
                REG_LED_ENABLE:    r_cfg.led_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_s_accept || (r_in_valid && !w_advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_item <= t_item'(s_axis_tdata[ITEM_W-1:0]);
        end
    end

    rtps_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_res);

    // a finished run never reports an active pulse
    `RTPS_ASSERT_IMP(a_done_not_active, w_step && w_res.outcome != OC_RUNNING, !w_res.pulse_active)
    // once an outcome has gone out, every later result repeats it
    `RTPS_ASSERT_IMP(a_outcome_sticky, w_step && r_out_valid && r_out_res.outcome != OC_RUNNING, w_res.outcome == r_out_res.outcome)
    // a tone command always carries a frequency and a length
    `RTPS_ASSERT_IMP(a_tone_has_payload, w_step && w_res.tone_command == CMD_TONE, w_res.tone_hz != '0 && w_res.tone_len_ms != '0)
    // a processed sample always lands in the result register
    `RTPS_ASSERT_NXT(a_step_fills_out, w_step, r_out_valid)

endmodule

@@ hdl/rtps_engine.sv @@
`timescale 1ns / 1ps

module rtps_engine #(
    parameter int TIME_WIDTH = rtps_pkg::TIME_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  rtps_pkg::t_item  i_item,
    input  rtps_pkg::t_cfg   i_cfg,
    output rtps_pkg::t_result o_res
);
    import rtps_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int CW = (TW > TOTAL_W) ? TW : TOTAL_W;

    // true when a is at or after b, modulo the timestamp range
    function automatic logic reached(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW-1:0] d;
        d = a - b;
        return !d[TW-1];
    endfunction

    // sequencer state
    logic          r_started,     n_started;
    logic [TW-1:0] r_start_time,  n_start_time;
    logic [TW-1:0] r_next_pulse,  n_next_pulse;
    logic [TW-1:0] r_pulse_end,   n_pulse_end;
    logic [TW-1:0] r_step_end,    n_step_end;
    logic [4:0]    r_step_index,  n_step_index;
    logic          r_playing,     n_playing;
    logic [TW-1:0] r_led_time,    n_led_time;
    logic          r_led_phase,   n_led_phase;
    t_outcome      r_outcome,     n_outcome;

    logic [TW-1:0] v_now;
    logic [TW-1:0] v_start;
    logic [TW-1:0] v_next;
    logic [TW-1:0] v_led_base;
    logic          v_phase;
    logic [CW-1:0] v_elapsed;
    logic          v_begin;
    logic [TW-1:0] v_pend;
    logic [TW-1:0] v_send;
    logic [4:0]    v_sidx;
    logic          v_play;
    logic [17:0]   v_pulse_ms;
    logic [2:0]    v_rhythm;
    logic [4:0]    v_len;
    logic [4:0]    v_idx;
    logic [4:0]    v_idx_inc;
    t_tone_step    v_tone;
    t_outcome      v_oc;
    logic [8:0]    v_led_thr;
    logic [TW-1:0] v_led_elapsed;

    assign v_now      = TW'(i_item.now_ms);
    assign v_pulse_ms = 18'(i_cfg.pulse_seconds) * 18'(MS_PER_SEC);

    // first sample latches the time bases
    assign v_start    = r_started ? r_start_time : v_now;
    assign v_next     = r_started ? r_next_pulse : v_now;
    assign v_led_base = r_started ? r_led_time : v_now;
    assign v_phase    = r_started ? r_led_phase : 1'b0;
    assign v_elapsed  = CW'(v_now - v_start);

    // button priority, then the overall time limit
    always_comb begin
        if (i_item.press_a) begin
            v_oc = OC_ACK;
        end else if (i_item.press_b) begin
            v_oc = OC_PASSED;
        end else if (i_item.power_short) begin
            v_oc = OC_DISMISSED;
        end else if (v_elapsed >= CW'(TOTAL_MS)) begin
            v_oc = OC_TIMEOUT;
        end else begin
            v_oc = OC_RUNNING;
        end
    end

    // pulse start and pattern step lookup
    assign v_begin   = !r_playing && reached(v_now, v_next);
    assign v_pend    = v_begin ? v_now + TW'(v_pulse_ms) : r_pulse_end;
    assign v_send    = v_begin ? v_now : r_step_end;
    assign v_sidx    = v_begin ? 5'd0 : r_step_index;
    assign v_play    = r_playing || v_begin;
    assign v_rhythm  = (i_cfg.rhythm_select < NUM_PATTERNS) ? i_cfg.rhythm_select : 3'd0;
    assign v_len     = pat_len(v_rhythm);
    assign v_idx     = (v_sidx < v_len) ? v_sidx : 5'd0;
    assign v_idx_inc = v_idx + 5'd1;
    assign v_tone    = rom_step(pat_base(v_rhythm) + 6'(v_idx));

    // next state and result for one sample
    always_comb begin
        n_started    = r_started;
        n_start_time = r_start_time;
        n_next_pulse = r_next_pulse;
        n_pulse_end  = r_pulse_end;
        n_step_end   = r_step_end;
        n_step_index = r_step_index;
        n_playing    = r_playing;
        n_led_time   = r_led_time;
        n_led_phase  = r_led_phase;
        n_outcome    = r_outcome;
        v_led_thr     = LED_SLOW_MS;
        v_led_elapsed = '0;

        o_res              = '0;
        o_res.tone_command = CMD_NONE;
        o_res.led_level    = 1'b1;
        o_res.outcome      = r_outcome;

        if (r_outcome != OC_RUNNING) begin
            // finished: idle until reset
            o_res.outcome = r_outcome;
        end else if (v_oc != OC_RUNNING) begin
            n_started    = 1'b1;
            n_start_time = v_start;
            n_next_pulse = v_next;
            n_led_time   = v_led_base;
            n_led_phase  = v_phase;
            n_outcome    = v_oc;
            n_playing    = 1'b0;
            o_res.outcome = v_oc;
            if (v_oc == OC_DISMISSED) begin
                o_res.tone_command = CMD_TONE;
                o_res.tone_hz      = POWER_TONE_HZ;
                o_res.tone_len_ms  = POWER_TONE_MS;
            end else begin
                o_res.tone_command = CMD_MUTE;
            end
        end else begin
            n_started    = 1'b1;
            n_start_time = v_start;
            n_next_pulse = v_begin ? v_now + TW'(PERIOD_MS) : v_next;
            n_pulse_end  = v_pend;
            n_step_end   = v_send;
            n_step_index = v_sidx;
            n_playing    = v_play;

            // pattern playback
            if (v_play) begin
                if (reached(v_now, v_pend)) begin
                    o_res.tone_command = CMD_MUTE;
                    n_playing          = 1'b0;
                end else if (reached(v_now, v_send)) begin
                    if (v_tone.hz != '0 && i_cfg.sound_enable && i_cfg.volume_level != '0) begin
                        o_res.tone_command = CMD_TONE;
                        o_res.tone_hz      = v_tone.hz;
                        o_res.tone_len_ms  = v_tone.ms;
                    end else begin
                        o_res.tone_command = CMD_MUTE;
                    end
                    n_step_end   = v_now + TW'(v_tone.ms);
                    n_step_index = (v_idx_inc == v_len) ? 5'd0 : v_idx_inc;
                end
            end

            // led blink, fast while a pulse plays
            v_led_thr     = n_playing ? LED_QUICK_MS : LED_SLOW_MS;
            v_led_elapsed = v_now - v_led_base;
            if (v_led_elapsed >= TW'(v_led_thr)) begin
                n_led_time  = v_now;
                n_led_phase = !v_phase;
            end else begin
                n_led_time  = v_led_base;
                n_led_phase = v_phase;
            end

            o_res.led_level    = !(i_cfg.led_enable && n_led_phase);
            o_res.pulse_active = n_playing;
        end
    end

    // state registers, advanced once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_start_time <= '0;
            r_next_pulse <= '0;
            r_pulse_end  <= '0;
            r_step_end   <= '0;
            r_step_index <= '0;
            r_playing    <= 1'b0;
            r_led_time   <= '0;
            r_led_phase  <= 1'b0;
            r_outcome    <= OC_RUNNING;
        end else if (i_step) begin
            r_started    <= n_started;
            r_start_time <= n_start_time;
            r_next_pulse <= n_next_pulse;
            r_pulse_end  <= n_pulse_end;
            r_step_end   <= n_step_end;
            r_step_index <= n_step_index;
            r_playing    <= n_playing;
            r_led_time   <= n_led_time;
            r_led_phase  <= n_led_phase;
            r_outcome    <= n_outcome;
        end
    end

endmodule
